FILE: rtl/sfb_pkg.sv
// Shared types, constants and segment tables of the seven-segment frame builder.
`default_nettype none
package sfb_pkg;

  // Request kinds (the fourth code has no meaning and is dropped)
  localparam logic [1:0] REQ_NUMBER = 2'd0;
  localparam logic [1:0] REQ_CHARS  = 2'd1;
  localparam logic [1:0] REQ_RESEND = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_DP_MASK      = 3'd0;
  localparam logic [2:0] CFG_BRIGHT_SMALL = 3'd1;
  localparam logic [2:0] CFG_BRIGHT_LARGE = 3'd2;
  localparam logic [2:0] CFG_HOLD_SMALL   = 3'd3;
  localparam logic [2:0] CFG_HOLD_LARGE   = 3'd4;

  localparam logic [7:0] MODE_FIXED    = 8'h44;
  localparam logic [7:0] BRIGHT_RESET  = 8'd143;
  localparam logic [7:0] SEG_MINUS     = 8'h40;
  localparam logic [7:0] SEG_UNKNOWN   = 8'h2D;
  localparam logic [13:0] SMALL_MAX    = 14'd999;
  localparam logic [13:0] LARGE_MAX    = 14'd9999;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [3:0] dp_mask;
    logic [7:0] bright_small;
    logic [7:0] bright_large;
    logic       hold_small;
    logic       hold_large;
  } cfg_t;

  typedef struct packed {
    logic             target;
    logic [1:0]       req;
    logic [13:0]      num;
    logic [3:0][7:0]  codes;
  } job_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rem;
  } dstep_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] letter_seg(input logic [4:0] l);
    logic [7:0] s;
    case (l)
      5'd0:    s = 8'h77;
      5'd1:    s = 8'h7C;
      5'd2:    s = 8'h39;
      5'd3:    s = 8'h5E;
      5'd4:    s = 8'h79;
      5'd5:    s = 8'h71;
      5'd6:    s = 8'h3D;
      5'd7:    s = 8'h76;
      5'd8:    s = 8'h10;
      5'd9:    s = 8'h0E;
      5'd10:   s = 8'h7A;
      5'd11:   s = 8'h38;
      5'd12:   s = 8'h55;
      5'd13:   s = 8'h54;
      5'd14:   s = 8'h5C;
      5'd15:   s = 8'h73;
      5'd16:   s = 8'h67;
      5'd17:   s = 8'h50;
      5'd18:   s = 8'h64;
      5'd19:   s = 8'h78;
      5'd20:   s = 8'h3E;
      5'd21:   s = 8'h62;
      5'd22:   s = 8'h6A;
      5'd23:   s = 8'h36;
      5'd24:   s = 8'h6E;
      5'd25:   s = 8'h49;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] char_code(input logic [7:0] ch);
    logic [7:0] s;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      s = digit_seg(4'(ch - 8'h30));
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s = letter_seg(5'(ch - 8'h61));
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      s = letter_seg(5'(ch - 8'h41));
    end else if (ch == 8'h20) begin
      s = 8'h00;
    end else if (ch == 8'h2D) begin
      s = SEG_MINUS;
    end else begin
      s = SEG_UNKNOWN;
    end
    return s;
  endfunction

  // Digit position 0..3 weighs 1000, 100, 10, 1
  function automatic logic [13:0] digit_weight(input logic [1:0] pos);
    logic [13:0] w;
    case (pos)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      2'd2:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

  // One decimal digit by four restoring compare-and-subtract steps
  function automatic dstep_t digit_step(input logic [13:0] rem, input logic [1:0] pos);
    dstep_t      r;
    logic [13:0] w;
    logic [13:0] trial;
    w       = digit_weight(pos);
    r.rem   = rem;
    r.digit = 4'd0;
    for (int j = 3; j >= 0; j--) begin
      trial = w << j;
      if (r.rem >= trial) begin
        r.rem      = r.rem - trial;
        r.digit[j] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] digit_addr(input logic target, input logic [1:0] pos);
    logic [7:0] a;
    case ({target, pos})
      3'b000:  a = 8'hC2;
      3'b001:  a = 8'hC4;
      3'b010:  a = 8'hC0;
      3'b100:  a = 8'hC6;
      3'b101:  a = 8'hC8;
      3'b110:  a = 8'hCA;
      3'b111:  a = 8'hCC;
      default: a = 8'hC0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sfb_front.sv
// Request front end: classify, saturate and character-code incoming items.
`default_nettype none
module sfb_front (
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    req_i,
  input  wire logic          target_i,
  input  wire logic [13:0]   number_i,
  input  wire logic [3:0][7:0] chars_i,
  input  wire sfb_pkg::cfg_t cfg_i,
  output logic               push_o,
  input  wire logic          push_ready_i,
  output sfb_pkg::job_t      job_o
);
  import sfb_pkg::*;

  logic keep;

  // Drop meaningless kinds and held displays; a resend bypasses the small hold
  always_comb begin
    keep = 1'b0;
    if (req_i == REQ_NUMBER || req_i == REQ_CHARS || req_i == REQ_RESEND) begin
      if (target_i) begin
        keep = !cfg_i.hold_large;
      end else begin
        keep = (req_i == REQ_RESEND) || !cfg_i.hold_small;
      end
    end
  end

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i && keep;

  always_comb begin
    job_o.target = target_i;
    job_o.req    = req_i;
    if (target_i) begin
      job_o.num = (number_i > LARGE_MAX) ? LARGE_MAX : number_i;
    end else begin
      job_o.num = (number_i > SMALL_MAX) ? SMALL_MAX : number_i;
    end
    for (int i = 0; i < 4; i++) begin
      job_o.codes[i] = char_code(chars_i[i]);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sfb_job_fifo.sv
// Two-entry job queue between front end and frame sequencer.
`default_nettype none
module sfb_job_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               push_ready_o,
  input  wire sfb_pkg::job_t job_i,
  output logic               pop_valid_o,
  input  wire logic          pop_i,
  output sfb_pkg::job_t      job_o
);
  import sfb_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign job_o        = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sfb_back.sv
// Frame sequencer: digit conversion, code store and command byte emission.
`default_nettype none
module sfb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sfb_pkg::cfg_t cfg_i,
  input  wire logic          job_valid_i,
  output logic               job_pop_o,
  input  wire sfb_pkg::job_t job_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_rel_o,
  output logic               out_last_o
);
  import sfb_pkg::*;

  back_state_e     state_q, state_d;
  logic            tgt_q, tgt_d;
  logic [13:0]     rem_q, rem_d;
  logic [1:0]      dig_q, dig_d;
  logic            lead_q, lead_d;
  logic [3:0]      idx_q, idx_d;
  logic [7:0]      emit_q [4];
  logic [7:0]      emit_d [4];
  logic [7:0]      small_q [3];
  logic [7:0]      small_d [3];
  logic [7:0]      large_q [4];
  logic [7:0]      large_d [4];
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_rel_q, out_rel_d;
  logic            out_last_q, out_last_d;

  dstep_t          step;
  logic [1:0]      pos;
  logic [7:0]      seg;
  logic            nz;
  logic            adv;
  logic            is_last;
  logic [1:0]      dsel;

  assign step    = digit_step(rem_q, dig_q);
  assign seg     = digit_seg(step.digit);
  assign nz      = lead_q || (step.digit != 4'd0) || (dig_q == 2'd3);
  assign pos     = tgt_q ? dig_q : 2'(dig_q - 2'd1);
  assign adv     = !out_valid_q || out_ready_i;
  assign is_last = tgt_q ? (idx_q == 4'd9) : (idx_q == 4'd7);
  assign dsel    = 2'(idx_q[3:1] - 3'd1);

  always_comb begin
    state_d     = state_q;
    tgt_d       = tgt_q;
    rem_d       = rem_q;
    dig_d       = dig_q;
    lead_d      = lead_q;
    idx_d       = idx_q;
    emit_d      = emit_q;
    small_d     = small_q;
    large_d     = large_q;
    out_byte_d  = out_byte_q;
    out_rel_d   = out_rel_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    job_pop_o   = 1'b0;

    case (state_q)
      B_IDLE: begin
        job_pop_o = job_valid_i;
        if (job_valid_i) begin
          tgt_d = job_i.target;
          idx_d = 4'd0;
          case (job_i.req)
            REQ_NUMBER: begin
              rem_d   = job_i.num;
              dig_d   = job_i.target ? 2'd0 : 2'd1;
              lead_d  = 1'b0;
              state_d = B_CONV;
            end
            REQ_CHARS: begin
              for (int i = 0; i < 4; i++) begin
                emit_d[i] = job_i.codes[i];
              end
              if (job_i.target) begin
                for (int i = 0; i < 4; i++) begin
                  large_d[i] = job_i.codes[i];
                end
              end else begin
                for (int i = 0; i < 3; i++) begin
                  small_d[i] = job_i.codes[i];
                end
              end
              state_d = B_EMIT;
            end
            default: begin
              // Resend: replay the stored codes
              if (job_i.target) begin
                emit_d = large_q;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  emit_d[i] = small_q[i];
                end
              end
              state_d = B_EMIT;
            end
          endcase
        end
      end

      B_CONV: begin
        rem_d  = step.rem;
        lead_d = nz;
        for (int i = 0; i < 4; i++) begin
          if (pos == 2'(i)) begin
            emit_d[i] = nz ? seg : 8'h00;
            if (tgt_q) begin
              large_d[i] = nz ? seg : 8'h00;
            end
          end
        end
        // The small display keeps its codes unblanked
        if (!tgt_q) begin
          for (int i = 0; i < 3; i++) begin
            if (pos == 2'(i)) begin
              small_d[i] = seg;
            end
          end
        end
        if (dig_q == 2'd3) begin
          state_d = B_EMIT;
        end else begin
          dig_d = dig_q + 2'd1;
        end
      end

      B_EMIT: begin
        if (adv) begin
          out_valid_d = 1'b1;
          out_last_d  = is_last;
          if (idx_q == 4'd0) begin
            out_byte_d = MODE_FIXED;
            out_rel_d  = 1'b1;
          end else if (is_last) begin
            out_byte_d = tgt_q ? cfg_i.bright_large : cfg_i.bright_small;
            out_rel_d  = 1'b1;
          end else if (idx_q[0]) begin
            out_byte_d = digit_addr(tgt_q, idx_q[2:1]);
            out_rel_d  = 1'b0;
          end else begin
            out_byte_d = emit_q[dsel] | {tgt_q && cfg_i.dp_mask[dsel], 7'b0};
            out_rel_d  = 1'b1;
          end
          idx_d = idx_q + 4'd1;
          if (is_last) begin
            state_d = B_IDLE;
          end
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        small_q[i] <= 8'h00;
      end
      for (int i = 0; i < 4; i++) begin
        large_q[i] <= 8'h00;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      small_q     <= small_d;
      large_q     <= large_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q      <= tgt_d;
    rem_q      <= rem_d;
    dig_q      <= dig_d;
    lead_q     <= lead_d;
    idx_q      <= idx_d;
    emit_q     <= emit_d;
    out_byte_q <= out_byte_d;
    out_rel_q  <= out_rel_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_rel_o   = out_rel_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

FILE: rtl/seven_seg_frame_builder.sv
// Top level of the seven-segment frame builder: configuration registers and wiring.
// Characters and resends go straight to emission once the item is taken; a number is first
// converted, one decimal digit a cycle, and its frame is emitted after the last digit.
// Throughput: one byte a cycle while the output is ready; the sequencer takes no new item
// until the last byte of a frame is in the output register. Reset: asynchronous, active low;
// clears the queue, the sequencer and the stored codes (blank), loads config reset values.
`default_nettype none
module seven_seg_frame_builder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: number[13:0], char_a[21:14], char_b[29:22], char_c[37:30],
  //        char_d[45:38], zero pad[47:46]
  input  wire logic [47:0] s_axis_tdata_i,
  // tuser: req_type[1:0], target[2]
  input  wire logic [2:0]  s_axis_tuser_i,
  // Command byte stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: cmd_byte[7:0]
  output logic [7:0]       m_axis_tdata_o,
  // tuser: strobe_release[0]
  output logic [0:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  import sfb_pkg::*;

  cfg_t            cfg_q, cfg_d;
  logic [3:0][7:0] chars;
  logic            push;
  logic            push_ready;
  job_t            job_in;
  job_t            job_out;
  logic            job_valid;
  logic            job_pop;

  // Configuration: always ready, writes beyond the register list are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DP_MASK:      cfg_d.dp_mask      = cfg_data_i[3:0];
        CFG_BRIGHT_SMALL: cfg_d.bright_small = cfg_data_i;
        CFG_BRIGHT_LARGE: cfg_d.bright_large = cfg_data_i;
        CFG_HOLD_SMALL:   cfg_d.hold_small   = cfg_data_i[0];
        CFG_HOLD_LARGE:   cfg_d.hold_large   = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dp_mask      <= 4'd0;
      cfg_q.bright_small <= BRIGHT_RESET;
      cfg_q.bright_large <= BRIGHT_RESET;
      cfg_q.hold_small   <= 1'b0;
      cfg_q.hold_large   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Unpack the characters, leftmost digit first
  assign chars[0] = s_axis_tdata_i[21:14];
  assign chars[1] = s_axis_tdata_i[29:22];
  assign chars[2] = s_axis_tdata_i[37:30];
  assign chars[3] = s_axis_tdata_i[45:38];

  // Front end: classify and drop, saturate, code the characters
  sfb_front u_front (
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .req_i        (s_axis_tuser_i[1:0]),
    .target_i     (s_axis_tuser_i[2]),
    .number_i     (s_axis_tdata_i[13:0]),
    .chars_i      (chars),
    .cfg_i        (cfg_q),
    .push_o       (push),
    .push_ready_i (push_ready),
    .job_o        (job_in)
  );

  // Queue: lets the front end take the next item while a frame is still going out
  sfb_job_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .job_i        (job_in),
    .pop_valid_o  (job_valid),
    .pop_i        (job_pop),
    .job_o        (job_out)
  );

  // Back end: convert, store codes, emit the frame through an output register
  sfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job_out),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_rel_o   (m_axis_tuser_o[0]),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire
